// ===== rtl/core/sed_pkg.sv =====
// ----------------------------------------------------------------------------
// sed_pkg
// Types and character constants shared by the string escape decoder files.
// ----------------------------------------------------------------------------
package sed_pkg;

  localparam int unsigned SED_FIFO_DEPTH = 4;

  localparam logic [7:0] SED_CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] SED_CHAR_QUOTE     = 8'h22;
  localparam logic [7:0] SED_CHAR_N         = 8'h6E;
  localparam logic [7:0] SED_CHAR_T         = 8'h74;
  localparam logic [7:0] SED_CHAR_ZERO      = 8'h30;
  localparam logic [7:0] SED_CHAR_SEVEN     = 8'h37;
  localparam logic [7:0] SED_CHAR_LF        = 8'h0A;
  localparam logic [7:0] SED_CHAR_TAB       = 8'h09;
  localparam logic [7:0] SED_CHAR_AT        = 8'h40;
  localparam logic [7:0] SED_CHAR_NUL       = 8'h00;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'b001,
    MODE_ESCAPE = 3'b010,
    MODE_OCTAL  = 3'b100
  } mode_e;

  typedef struct packed {
    logic [7:0] char_out;
    logic       unknown_escape;
    logic       octal_overflow;
    logic       end_of_string;
  } result_t;

  typedef struct packed {
    logic       v0;
    logic       v1;
    result_t    r0;
    result_t    r1;
    mode_e      mode_d;
    logic [8:0] acc_d;
    logic [1:0] cnt_d;
  } step_t;

endpackage

// ===== rtl/core/sed_if.sv =====
// ----------------------------------------------------------------------------
// sed_if
// Valid/ready channels for raw input bytes and decoded result bytes.
// ----------------------------------------------------------------------------
interface sed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       is_last;

  modport source (output valid, output char_in, output is_last, input ready);
  modport sink (input valid, input char_in, input is_last, output ready);
endinterface

interface sed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;
  logic       unknown_escape;
  logic       octal_overflow;
  logic       end_of_string;

  modport source (output valid, output char_out, output unknown_escape,
                  output octal_overflow, output end_of_string, input ready);
  modport sink (input valid, input char_out, input unknown_escape,
                input octal_overflow, input end_of_string, output ready);
endinterface

// ===== rtl/core/sed_decode.sv =====
// ----------------------------------------------------------------------------
// sed_decode
// Next-state and result logic for one input byte of a literal body.
// ----------------------------------------------------------------------------
module sed_decode (
  input  logic           [7:0] char_i,
  input  logic                 last_i,
  input  sed_pkg::mode_e       mode_i,
  input  logic           [8:0] acc_i,
  input  logic           [1:0] cnt_i,
  output sed_pkg::step_t       step_o
);
  import sed_pkg::*;

  function automatic result_t oct_result(logic [8:0] code, logic eos);
    result_t r;
    r.char_out       = code[8] ? SED_CHAR_AT : code[7:0];
    r.unknown_escape = 1'b0;
    r.octal_overflow = code[8];
    r.end_of_string  = eos;
    return r;
  endfunction

  logic       is_oct;
  logic [2:0] digit;
  logic [8:0] acc_shift;
  logic [1:0] cnt_inc;
  logic       norm_v;
  logic       norm_esc;
  result_t    norm_r;

  assign is_oct    = (char_i >= SED_CHAR_ZERO) && (char_i <= SED_CHAR_SEVEN);
  assign digit     = char_i[2:0];
  assign acc_shift = {acc_i[5:0], digit};
  assign cnt_inc   = cnt_i + 2'd1;

  always_comb begin
    if (char_i == SED_CHAR_BACKSLASH) begin
      norm_v   = last_i;
      norm_esc = !last_i;
      norm_r   = '{char_out: SED_CHAR_NUL, unknown_escape: 1'b1,
                   octal_overflow: 1'b0, end_of_string: 1'b1};
    end else begin
      norm_v   = 1'b1;
      norm_esc = 1'b0;
      norm_r   = '{char_out: char_i, unknown_escape: 1'b0,
                   octal_overflow: 1'b0, end_of_string: last_i};
    end
  end

  always_comb begin
    step_o        = '0;
    step_o.mode_d = MODE_NORMAL;
    unique case (mode_i)
      MODE_OCTAL: begin
        if (is_oct) begin
          if ((cnt_inc == 2'd3) || last_i) begin
            step_o.v0 = 1'b1;
            step_o.r0 = oct_result(acc_shift, last_i);
          end else begin
            step_o.mode_d = MODE_OCTAL;
            step_o.acc_d  = acc_shift;
            step_o.cnt_d  = cnt_inc;
          end
        end else begin
          step_o.v0     = 1'b1;
          step_o.r0     = oct_result(acc_i, 1'b0);
          step_o.v1     = norm_v;
          step_o.r1     = norm_r;
          step_o.mode_d = norm_esc ? MODE_ESCAPE : MODE_NORMAL;
        end
      end
      MODE_ESCAPE: begin
        if (is_oct) begin
          if (last_i) begin
            step_o.v0 = 1'b1;
            step_o.r0 = oct_result({6'd0, digit}, 1'b1);
          end else begin
            step_o.mode_d = MODE_OCTAL;
            step_o.acc_d  = {6'd0, digit};
            step_o.cnt_d  = 2'd1;
          end
        end else begin
          step_o.v0               = 1'b1;
          step_o.r0.end_of_string = last_i;
          case (char_i) inside
            SED_CHAR_N:                        step_o.r0.char_out = SED_CHAR_LF;
            SED_CHAR_T:                        step_o.r0.char_out = SED_CHAR_TAB;
            SED_CHAR_BACKSLASH, SED_CHAR_QUOTE: step_o.r0.char_out = char_i;
            default: begin
              step_o.r0.char_out       = char_i;
              step_o.r0.unknown_escape = 1'b1;
            end
          endcase
        end
      end
      default: begin
        step_o.v0     = norm_v;
        step_o.r0     = norm_r;
        step_o.mode_d = norm_esc ? MODE_ESCAPE : MODE_NORMAL;
      end
    endcase
  end

endmodule

// ===== rtl/core/sed_fifo.sv =====
// ----------------------------------------------------------------------------
// sed_fifo
// Result queue that takes up to two entries per cycle and gives one.
// ----------------------------------------------------------------------------
module sed_fifo #(
  parameter int unsigned Depth = sed_pkg::SED_FIFO_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic       [1:0] push_i,
  input  sed_pkg::result_t data0_i,
  input  sed_pkg::result_t data1_i,
  output logic             space_o,
  output logic             valid_o,
  input  logic             ready_i,
  output sed_pkg::result_t data_o
);
  import sed_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  result_t             mem_q [Depth];
  logic     [PtrW-1:0] wr_q, wr_d, rd_q, rd_d, wr_nxt;
  logic     [CntW-1:0] cnt_q, cnt_d;
  logic                pop;

  assign wr_nxt  = ptr_inc(wr_q);
  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign space_o = (cnt_q <= CntW'(Depth - 2));
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d = wr_q;
    if (push_i[1]) begin
      wr_d = ptr_inc(wr_nxt);
    end else if (push_i[0]) begin
      wr_d = wr_nxt;
    end
    rd_d  = pop ? ptr_inc(rd_q) : rd_q;
    cnt_d = cnt_q + CntW'(push_i[0]) + CntW'(push_i[1]) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i[0]) begin
      mem_q[wr_q] <= data0_i;
    end
    if (push_i[1]) begin
      mem_q[wr_nxt] <= data1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/core/string_escape_decoder.sv =====
// ----------------------------------------------------------------------------
// string_escape_decoder
// Decodes escape sequences in the body of a string literal, one byte per
// transaction, into a stream of decoded bytes with status flags.
// ----------------------------------------------------------------------------
//   Channel  Dir  Payload                                        Results
//   in_i     in   char_in[7:0], is_last                          -
//   out_o    out  char_out[7:0], unknown_escape, octal_overflow,  0..2 per input
//                 end_of_string
//
// One input transaction is taken per cycle while the result queue has two
// free entries; results are registered in the queue before they reach out_o.
// An input that ends an octal run with a non-octal byte gives two results
// unless that byte is a non-final backslash; results leave the queue one at
// a time, so the queue depth sets how long in_i keeps going while out_o stalls.
// Reset returns the decoder to normal mode and empties the queue.
module string_escape_decoder #(
  parameter int unsigned FifoDepth = sed_pkg::SED_FIFO_DEPTH
) (
  input logic       clk_i,
  input logic       rst_ni,
  sed_in_if.sink    in_i,
  sed_out_if.source out_o
);
  import sed_pkg::*;

  mode_e      mode_q;
  logic [8:0] acc_q;
  logic [1:0] cnt_q;
  step_t      step;
  logic       accept;
  logic       space;
  logic [1:0] push;
  result_t    head;

  sed_decode u_decode (
    .char_i (in_i.char_in),
    .last_i (in_i.is_last),
    .mode_i (mode_q),
    .acc_i  (acc_q),
    .cnt_i  (cnt_q),
    .step_o (step)
  );

  assign in_i.ready = space;
  assign accept     = in_i.valid && space;
  assign push       = accept ? {step.v1, step.v0} : 2'b00;

  sed_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data0_i (step.r0),
    .data1_i (step.r1),
    .space_o (space),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (head)
  );

  assign out_o.char_out       = head.char_out;
  assign out_o.unknown_escape = head.unknown_escape;
  assign out_o.octal_overflow = head.octal_overflow;
  assign out_o.end_of_string  = head.end_of_string;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      acc_q  <= '0;
      cnt_q  <= '0;
    end else if (accept) begin
      mode_q <= step.mode_d;
      acc_q  <= step.acc_d;
      cnt_q  <= step.cnt_d;
    end
  end

endmodule

// ===== rtl/core/sed_checker.sv =====
// ----------------------------------------------------------------------------
// sed_checker
// Port-level checks for the string escape decoder, bound to its top level.
// ----------------------------------------------------------------------------
module sed_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       in_last_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_char_i
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its byte.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_char_i))
    else $error("result byte changed while stalled");

  // The final byte of a literal always produces a result.
  a_last_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> out_valid_i)
    else $error("no result after the final byte");

  // The input side only backs up behind pending results.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with an empty result queue");

endmodule

bind string_escape_decoder sed_checker u_sed_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.is_last),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_char_i  (out_o.char_out)
);

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the string escape decoder. Raw literal bytes are
// driven on the input channel in bursts. Each accepted byte is run through a
// behavioral decoder that queues the bytes and flags the block must emit. The
// result channel stalls on changing patterns, and every result transaction is
// compared field by field against the oldest queued byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import sed_pkg::*;

  typedef enum int {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_PATTERN,
    SINK_THROTTLED
  } sink_kind_e;

  logic clk;
  logic rst_n;

  sed_in_if  in_ch ();
  sed_out_if out_ch ();

  string_escape_decoder DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  mode_e      dec_mode;
  logic [8:0] octal_code;
  logic [1:0] octal_digits;
  result_t    pending_decoded[$];
  int         mismatch_count;
  int         items_sent;
  int         burst_left;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic clear_decoder();
    dec_mode     = MODE_NORMAL;
    octal_code   = '0;
    octal_digits = '0;
  endtask

  task automatic queue_decoded(input logic [7:0] c, input logic unk, input logic ovf,
                               input logic eos);
    result_t r;
    r.char_out       = c;
    r.unknown_escape = unk;
    r.octal_overflow = ovf;
    r.end_of_string  = eos;
    pending_decoded = {pending_decoded, r};
  endtask

  task automatic flush_octal(input logic eos);
    if (octal_code > 9'h0FF) begin
      queue_decoded(SED_CHAR_AT, 1'b0, 1'b1, eos);
    end else begin
      queue_decoded(octal_code[7:0], 1'b0, 1'b0, eos);
    end
    clear_decoder();
  endtask

  task automatic decode_step(input logic [7:0] c, input logic last);
    logic octal_digit;
    logic plain;
    octal_digit = (c >= SED_CHAR_ZERO) && (c <= SED_CHAR_SEVEN);
    plain = 1'b1;
    if (dec_mode == MODE_OCTAL) begin
      if (octal_digit) begin
        octal_code   = {octal_code[5:0], c[2:0]};
        octal_digits = octal_digits + 2'd1;
        if (octal_digits == 2'd3 || last) begin
          flush_octal(last);
        end
        plain = 1'b0;
      end else begin
        flush_octal(1'b0);
      end
    end else if (dec_mode == MODE_ESCAPE) begin
      plain = 1'b0;
      dec_mode = MODE_NORMAL;
      if (octal_digit) begin
        octal_code   = {6'd0, c[2:0]};
        octal_digits = 2'd1;
        dec_mode     = MODE_OCTAL;
        if (last) begin
          flush_octal(1'b1);
        end
      end else if (c == SED_CHAR_N) begin
        queue_decoded(SED_CHAR_LF, 1'b0, 1'b0, last);
      end else if (c == SED_CHAR_T) begin
        queue_decoded(SED_CHAR_TAB, 1'b0, 1'b0, last);
      end else if (c == SED_CHAR_BACKSLASH || c == SED_CHAR_QUOTE) begin
        queue_decoded(c, 1'b0, 1'b0, last);
      end else begin
        queue_decoded(c, 1'b1, 1'b0, last);
      end
    end
    if (plain) begin
      dec_mode = MODE_NORMAL;
      if (c == SED_CHAR_BACKSLASH) begin
        if (last) begin
          queue_decoded(SED_CHAR_NUL, 1'b1, 1'b0, 1'b1);
        end else begin
          dec_mode = MODE_ESCAPE;
        end
      end else begin
        queue_decoded(c, 1'b0, 1'b0, last);
      end
    end
    if (last) begin
      clear_decoder();
    end
  endtask

  task automatic send_byte(input logic [7:0] c, input logic last);
    int   gap;
    logic take;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid   <= 1'b1;
    in_ch.char_in <= c;
    in_ch.is_last <= last;
    take = 1'b0;
    while (!take) begin
      @(negedge clk);
      take = in_ch.ready;
      if (take) begin
        decode_step(c, last);
      end
      @(posedge clk);
    end
    items_sent++;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending_decoded.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  task automatic test_plain_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_named_escapes();
    send_byte(SED_CHAR_BACKSLASH, 1'b0);
    send_byte(SED_CHAR_N, 1'b0);
    send_byte(SED_CHAR_BACKSLASH, 1'b0);
    send_byte(SED_CHAR_T, 1'b0);
    send_byte(SED_CHAR_BACKSLASH, 1'b0);
    send_byte(SED_CHAR_BACKSLASH, 1'b0);
    send_byte(SED_CHAR_BACKSLASH, 1'b0);
    send_byte(SED_CHAR_QUOTE, 1'b0);
    send_byte(SED_CHAR_BACKSLASH, 1'b0);
    send_byte(8'h71, 1'b1);
  endtask

  // Covers overflow on a full run, a letter and a backslash ending a run,
  // a trailing backslash, and a literal that ends inside a run.
  task automatic test_octal_runs();
    send_byte(SED_CHAR_BACKSLASH, 1'b0);
    send_byte(SED_CHAR_SEVEN, 1'b0);
    send_byte(SED_CHAR_SEVEN, 1'b0);
    send_byte(SED_CHAR_SEVEN, 1'b0);
    send_byte(SED_CHAR_BACKSLASH, 1'b0);
    send_byte(SED_CHAR_ZERO + 8'd1, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(SED_CHAR_BACKSLASH, 1'b0);
    send_byte(SED_CHAR_ZERO + 8'd1, 1'b0);
    send_byte(SED_CHAR_ZERO + 8'd2, 1'b0);
    send_byte(SED_CHAR_BACKSLASH, 1'b1);
    send_byte(SED_CHAR_BACKSLASH, 1'b0);
    send_byte(SED_CHAR_ZERO + 8'd5, 1'b1);
  endtask

  task automatic test_drain_pause();
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(SED_CHAR_BACKSLASH, 1'b0);
    send_byte(SED_CHAR_ZERO + 8'd6, 1'b0);
    in_ch.valid <= 1'b0;
    wait_drained();
    send_byte(SED_CHAR_ZERO + 8'd5, 1'b0);
    send_byte(8'h78, 1'b1);
  endtask

  task automatic send_random_literal();
    logic [7:0] body[$];
    int         tokens;
    int         digits;
    tokens = $urandom_range(1, 10);
    repeat (tokens) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: body = {body, 8'($urandom_range(0, 255))};
        4: begin
          body = {body, SED_CHAR_BACKSLASH};
          case ($urandom_range(0, 3))
            0: body = {body, SED_CHAR_N};
            1: body = {body, SED_CHAR_T};
            2: body = {body, SED_CHAR_BACKSLASH};
            default: body = {body, SED_CHAR_QUOTE};
          endcase
        end
        5: begin
          body = {body, SED_CHAR_BACKSLASH};
          body = {body, 8'($urandom_range(0, 255))};
        end
        9: body = {body, SED_CHAR_BACKSLASH};
        default: begin
          body = {body, SED_CHAR_BACKSLASH};
          digits = $urandom_range(1, 3);
          repeat (digits) body = {body, 8'(SED_CHAR_ZERO + 8'($urandom_range(0, 7)))};
        end
      endcase
    end
    foreach (body[i]) begin
      send_byte(body[i], i == body.size() - 1);
    end
  endtask

  task automatic send_noise_literal();
    int         count;
    logic [7:0] c;
    count = $urandom_range(1, 12);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: c = SED_CHAR_BACKSLASH;
        1: c = SED_CHAR_ZERO + 8'($urandom_range(0, 7));
        default: c = 8'($urandom_range(0, 255));
      endcase
      send_byte(c, i == count - 1);
    end
  endtask

  task automatic test_random_literals();
    int target;
    target = items_sent + 1000;
    while (items_sent < target) begin
      if ($urandom_range(0, 5) == 0) begin
        send_noise_literal();
      end else begin
        send_random_literal();
      end
      if ($urandom_range(0, 39) == 0) begin
        in_ch.valid <= 1'b0;
        wait_drained();
      end
    end
  endtask

  initial begin : result_sink
    sink_kind_e  kind;
    int          phase_left;
    logic [12:0] pattern;
    out_ch.ready = 1'b0;
    kind = SINK_OPEN;
    phase_left = 0;
    pattern = 13'b1011001110101;
    forever begin
      @(posedge clk);
      if (phase_left == 0) begin
        kind = sink_kind_e'($urandom_range(0, 3));
        phase_left = $urandom_range(20, 300);
      end
      phase_left--;
      pattern = {pattern[11:0], pattern[12]};
      case (kind)
        SINK_OPEN:    out_ch.ready <= 1'b1;
        SINK_RANDOM:  out_ch.ready <= ($urandom_range(0, 3) != 0);
        SINK_PATTERN: out_ch.ready <= pattern[0];
        default:      out_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  initial begin : result_check
    result_t got;
    result_t want;
    logic    hit;
    forever begin
      @(negedge clk);
      hit = rst_n && out_ch.valid && out_ch.ready;
      got.char_out       = out_ch.char_out;
      got.unknown_escape = out_ch.unknown_escape;
      got.octal_overflow = out_ch.octal_overflow;
      got.end_of_string  = out_ch.end_of_string;
      @(posedge clk);
      if (hit) begin
        if (pending_decoded.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        end else begin
          want = pending_decoded.pop_front();
          check_field("char_out", want.char_out, got.char_out);
          check_field("unknown_escape", 8'(want.unknown_escape), 8'(got.unknown_escape));
          check_field("octal_overflow", 8'(want.octal_overflow), 8'(got.octal_overflow));
          check_field("end_of_string", 8'(want.end_of_string), 8'(got.end_of_string));
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.char_in = 8'h00;
    in_ch.is_last = 1'b0;
    rst_n = 1'b0;
    mismatch_count = 0;
    items_sent = 0;
    burst_left = 0;
    clear_decoder();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_plain_bytes();
    test_named_escapes();
    test_octal_runs();
    test_drain_pause();
    test_random_literals();
    in_ch.valid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
